[hdl/isst_pkg.sv]
// shared types and constants for the interpolation search block
`timescale 1ns / 1ps
package isst_pkg;

    // width of one table word and of a difference of two words
    localparam int ENTRY_W = 32;
    localparam int DIFF_W  = ENTRY_W + 1;

    // item kinds carried on the input tuser
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // search sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_LEFT,
        S_RIGHT,
        S_CHK,
        S_MUL,
        S_DIVST,
        S_DIV,
        S_PROBE,
        S_CMP,
        S_DONE
    } t_isst_state;

    // control from the sequencer to the divider
    typedef struct packed {
        logic start;
    } t_div_ctl;

    // status from the divider back to the sequencer
    typedef struct packed {
        logic done;
    } t_div_sts;

endpackage

[hdl/interpolation_search_sorted_table.sv]
// interpolation search over a sorted table of signed words
//
// Load beats write one table word and produce no result.
// A search beat probes at left + (key - a[left]) * (right - left) /
// (a[right] - a[left]), narrowing the window until the key is hit or cannot be
// in it. Each probe takes two reads of the single table read port for the window
// ends, a multiply step and a restoring divider that yields one quotient bit per
// cycle (both skipped when the end values are equal), and one read of the probed
// word. A search can also end early at the range check. The input is not ready
// while a search runs. A search result sits in an output register, so load
// beats are taken while it waits. The table contents are undefined until
// written.
`timescale 1ns / 1ps
module interpolation_search_sorted_table #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: entries_in_use
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // slot[9:0], entry_value[41:10], search_key[73:42]
    input  logic        s_axis_tuser,  // func
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // found[0], position[10:1], probe_count[21:11]
);
    import isst_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LW = AW + 2;
    localparam int XW = ((AW > 10) ? AW : 10) + 1;
    localparam int CW = ((AW + 1) > 11) ? (AW + 1) : 11;
    localparam int PW = DIFF_W + AW;
    localparam logic [XW-1:0] DEPTH_X = XW'(TABLE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    t_isst_state r_state, n_state;

    logic [10:0]              r_entries;
    logic signed [LW-1:0]     r_left, n_left;
    logic signed [LW-1:0]     r_right, n_right;
    logic signed [LW-1:0]     r_m, n_m;
    logic signed [ENTRY_W-1:0] r_key, n_key;
    logic signed [ENTRY_W-1:0] r_lo, n_lo;
    logic [DIFF_W-1:0]        r_num, n_num;
    logic [DIFF_W-1:0]        r_den, n_den;
    logic [AW-1:0]            r_span, n_span;
    logic [PW-1:0]            r_prod, n_prod;
    logic [10:0]              r_probes, n_probes;
    logic                     r_found, n_found;
    logic [9:0]               r_pos, n_pos;
    logic                     r_out_valid, n_out_valid;
    logic [10:0]              r_out_cnt, n_out_cnt;
    logic                     r_out_found, n_out_found;
    logic [9:0]               r_out_pos, n_out_pos;

    logic [ENTRY_W-1:0]       r_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0]       r_rdata;
    logic [AW-1:0]            rd_addr;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;

    logic                     in_acc;
    logic [9:0]               in_slot;
    logic [XW-1:0]            slot_x;
    logic [CW-1:0]            ent_x;
    logic [CW-1:0]            n_use;
    logic signed [ENTRY_W-1:0] rd_val;
    logic signed [DIFF_W-1:0] key_x, lo_x, hi_x;
    logic signed [LW-1:0]     m_sum;
    logic [XW-1:0]            pos_x;

    t_div_ctl                 div_ctl;
    t_div_sts                 div_sts;
    logic [AW-1:0]            div_q;

    // configuration register, always ready
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= 11'd1;
        end else if (i_cfg_valid) begin
            r_entries <= i_cfg_data;
        end
    end

    // input beat fields
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_slot       = s_axis_tdata[9:0];
    assign slot_x        = XW'(in_slot);
    assign wr_addr       = slot_x[AW-1:0];
    assign wr_en         = in_acc && (s_axis_tuser == FUNC_LOAD) && (slot_x < DEPTH_X);

    // clamp of the entry count to [1, TABLE_DEPTH]
    assign ent_x = CW'(r_entries);
    always_comb begin
        priority if (ent_x == '0) begin
            n_use = CW'(1);
        end else if (ent_x > DEPTH_C) begin
            n_use = DEPTH_C;
        end else begin
            n_use = ent_x;
        end
    end

    // table read address follows the sequencer
    always_comb begin
        unique case (r_state)
            S_LEFT:  rd_addr = r_left[AW-1:0];
            S_RIGHT: rd_addr = r_right[AW-1:0];
            default: rd_addr = r_m[AW-1:0];
        endcase
    end

    // table storage, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= s_axis_tdata[41:10];
        end
        r_rdata <= r_mem[rd_addr];
    end

    assign rd_val = $signed(r_rdata);
    assign key_x  = DIFF_W'(r_key);
    assign lo_x   = DIFF_W'(r_lo);
    assign hi_x   = DIFF_W'(rd_val);
    assign m_sum  = r_left + $signed(LW'(div_q));
    assign pos_x  = XW'(r_m[AW-1:0]);

    // divider for the probe position
    isst_div #(
        .QW (AW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (r_prod),
        .i_divisor  (r_den),
        .o_sts      (div_sts),
        .o_quot     (div_q)
    );

    // search sequencer
    always_comb begin
        n_state     = r_state;
        n_left      = r_left;
        n_right     = r_right;
        n_m         = r_m;
        n_key       = r_key;
        n_lo        = r_lo;
        n_num       = r_num;
        n_den       = r_den;
        n_span      = r_span;
        n_prod      = r_prod;
        n_probes    = r_probes;
        n_found     = r_found;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        n_out_cnt   = r_out_cnt;
        n_out_found = r_out_found;
        n_out_pos   = r_out_pos;
        div_ctl.start = 1'b0;

        // result beat leaves
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (s_axis_tuser == FUNC_SEARCH)) begin
                    n_key    = $signed(s_axis_tdata[73:42]);
                    n_left   = '0;
                    n_right  = $signed(LW'(n_use[AW:0])) - LW'(1);
                    n_probes = '0;
                    n_found  = 1'b0;
                    n_pos    = '0;
                    n_state  = S_LEFT;
                end
            end
            S_LEFT: begin
                n_probes = r_probes + 11'd1;
                if (r_left > r_right) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RIGHT;
                end
            end
            S_RIGHT: begin
                n_lo    = rd_val;
                n_state = S_CHK;
            end
            S_CHK: begin
                // window end values and the range check
                if ((r_key < r_lo) || (r_key > rd_val)) begin
                    n_state = S_DONE;
                end else if (rd_val == r_lo) begin
                    n_m     = r_left;
                    n_state = S_PROBE;
                end else begin
                    n_num   = DIFF_W'(key_x - lo_x);
                    n_den   = DIFF_W'(hi_x - lo_x);
                    n_span  = AW'(r_right - r_left);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = PW'(r_num * r_span);
                n_state = S_DIVST;
            end
            S_DIVST: begin
                div_ctl.start = 1'b1;
                n_state       = S_DIV;
            end
            S_DIV: begin
                if (div_sts.done) begin
                    if (m_sum > r_right) begin
                        n_m = r_right;
                    end else begin
                        n_m = m_sum;
                    end
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                priority if (rd_val == r_key) begin
                    n_found = 1'b1;
                    n_pos   = pos_x[9:0];
                    n_state = S_DONE;
                end else if (r_left == r_right) begin
                    n_state = S_DONE;
                end else if (r_key > rd_val) begin
                    n_left  = r_m + LW'(1);
                    n_state = S_LEFT;
                end else begin
                    n_right = r_m - LW'(1);
                    n_state = S_LEFT;
                end
            end
            S_DONE: begin
                // hand the result to the output register once it is free
                if (!n_out_valid) begin
                    n_out_valid = 1'b1;
                    n_out_cnt   = r_probes;
                    n_out_found = r_found;
                    n_out_pos   = r_pos;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_left      <= n_left;
        r_right     <= n_right;
        r_m         <= n_m;
        r_key       <= n_key;
        r_lo        <= n_lo;
        r_num       <= n_num;
        r_den       <= n_den;
        r_span      <= n_span;
        r_prod      <= n_prod;
        r_probes    <= n_probes;
        r_found     <= n_found;
        r_pos       <= n_pos;
        r_out_cnt   <= n_out_cnt;
        r_out_found <= n_out_found;
        r_out_pos   <= n_out_pos;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_cnt, r_out_pos, r_out_found};

endmodule

[hdl/isst_div.sv]
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module isst_div #(
    parameter int QW = 10
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  isst_pkg::t_div_ctl                         i_ctl,
    input  logic [isst_pkg::DIFF_W+QW-1:0]             i_dividend,
    input  logic [isst_pkg::DIFF_W-1:0]                i_divisor,
    output isst_pkg::t_div_sts                         o_sts,
    output logic [QW-1:0]                              o_quot
);
    import isst_pkg::*;

    localparam int CNTW = $clog2(QW + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNTW-1:0]   r_cnt, n_cnt;
    logic [DIFF_W-1:0] r_rem, n_rem;
    logic [DIFF_W-1:0] r_den, n_den;
    logic [QW-1:0]     r_low, n_low;
    logic [QW-1:0]     r_q, n_q;
    logic [DIFF_W:0]   trial;
    logic [DIFF_W:0]   den_x;

    // one shift, compare and subtract step
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_low  = r_low;
        n_q    = r_q;
        trial  = {r_rem, r_low[QW-1]};
        den_x  = {1'b0, r_den};
        if (i_ctl.start) begin
            // upper part of the dividend is already below the divisor
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_dividend[DIFF_W+QW-1:QW];
            n_low  = i_dividend[QW-1:0];
            n_den  = i_divisor;
            n_q    = '0;
        end else if (r_busy) begin
            if (trial >= den_x) begin
                n_rem = DIFF_W'(trial - den_x);
                n_q   = QW'({r_q, 1'b1});
            end else begin
                n_rem = trial[DIFF_W-1:0];
                n_q   = QW'({r_q, 1'b0});
            end
            n_low = r_low << 1;
            n_cnt = CNTW'(r_cnt + 1'b1);
            if (r_cnt == CNTW'(QW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_low <= n_low;
        r_q   <= n_q;
    end

    assign o_sts.done = r_done;
    assign o_quot     = r_q;

endmodule
